// ===== rtl/core/ssq_pkg.sv =====
// ---------------------------------------------------------------------------
// ssq_pkg
// Shared types and codes for the state stack with per-level event queues.
// ---------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

  localparam int EVENT_W = 7;
  localparam int STATE_W = 6;
  localparam int OP_W    = 3;
  localparam int DEPTH_W = 4;
  localparam int LEVEL_W = 4;
  localparam int STAT_W  = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_POST    = 3'd0;
  localparam logic [OP_W-1:0] OP_GET     = 3'd1;
  localparam logic [OP_W-1:0] OP_SET     = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd3;
  localparam logic [OP_W-1:0] OP_POP     = 3'd4;
  localparam logic [OP_W-1:0] OP_DISCARD = 3'd5;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_QFULL    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BADDEPTH = 3'd3;
  localparam logic [STAT_W-1:0] STAT_MIGDROP  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [EVENT_W-1:0] event_code;
    logic [STATE_W-1:0] target_state;
    logic               force_change;
    logic [DEPTH_W-1:0] query_depth;
  } cmd_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_out;
    logic               event_valid;
    logic [STATE_W-1:0] state_out;
    logic [STATE_W-1:0] previous_state;
    logic               state_changed;
    logic [LEVEL_W-1:0] stack_level;
    logic [STATE_W-1:0] pushed_state;
    logic               pushed_valid;
    logic [STAT_W-1:0]  status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/state_stack_event_queues_core.sv =====
// ---------------------------------------------------------------------------
// state_stack_event_queues_core
// Stack of state levels, each with a ring queue of event codes.
// ---------------------------------------------------------------------------
//
//  channel | dir | carries                          | handshake
//  --------+-----+----------------------------------+---------------------
//  s_*     | in  | one operation item               | s_tvalid & s_tready
//  m_*     | out | one result item per operation    | m_tvalid & m_tready
//
//  Per item: post, set, push, unused codes and a depth-0 query are done in
//  the idle state; get on a non-empty queue reads the event RAM, and a deeper
//  query the level RAM. Discard and pop at the bottom level change nothing;
//  above it, discard reloads the top from the level RAM, while pop first moves
//  the events left in the top queue into the level below, one event per cycle.
//  Reset: rst clears the sequencer, the top level index and its state and
//  queue pointers; RAM contents are not cleared.
//  Stalls: the result register frees the sequencer; a new item is taken
//  while a finished result waits, and a second result waits on m_tready.
//
//  Storage: the top level lives in registers; lower levels sit in a small
//  level RAM (state, head, tail) and all event queues in one event RAM
//  addressed by {level, slot}.
// ---------------------------------------------------------------------------
`default_nettype none

module state_stack_event_queues_core #(
  parameter int QUEUE_DEPTH = 32,
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tuser: opcode[2:0]
  input  wire logic [2:0]  s_tuser,
  // s_tdata: event_code[6:0], target_state[12:7], force_change[13],
  //          query_depth[17:14], zero fill[23:18]
  input  wire logic [23:0] s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // m_tdata: event_out[6:0], event_valid[7], state_out[13:8],
  //          previous_state[19:14], state_changed[20], stack_level[24:21],
  //          pushed_state[30:25], pushed_valid[31], status[34:32],
  //          zero fill[39:35]
  output logic [39:0]      m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready
);
  import ssq_pkg::*;

  cmd_t cmd;
  res_t res;
  logic res_load;
  logic out_free;

  // unpack the input item
  assign cmd.opcode       = s_tuser;
  assign cmd.event_code   = s_tdata[6:0];
  assign cmd.target_state = s_tdata[12:7];
  assign cmd.force_change = s_tdata[13];
  assign cmd.query_depth  = s_tdata[17:14];

  // output slot is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  ssq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (cmd),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {5'd0, res.status, res.pushed_valid, res.pushed_state,
                  res.stack_level, res.state_changed, res.previous_state,
                  res.state_out, res.event_valid, res.event_out};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssq_ram.sv =====
// ---------------------------------------------------------------------------
// ssq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module ssq_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssq_ctrl.sv =====
// ---------------------------------------------------------------------------
// ssq_ctrl
// Sequencer: keeps the top level in registers, lower levels and all event
// queues in RAM, and steps one memory access per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ssq_ctrl #(
  parameter int QUEUE_DEPTH = 32,
  parameter int STACK_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ssq_pkg::cmd_t in_cmd,
  input  wire logic          out_free,
  output logic               res_load,
  output ssq_pkg::res_t      res
);
  import ssq_pkg::*;

  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW  = (SW > DEPTH_W) ? SW : DEPTH_W;
  localparam int LW  = STATE_W + 2 * QW;
  localparam int EAW = SW + QW;
  localparam logic [SW-1:0] TOP_MAX = SW'(STACK_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GETRD = 3'd1;
  localparam logic [2:0] S_LVRD  = 3'd2;
  localparam logic [2:0] S_MIG   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_BELOW = 3'd5;
  localparam logic [2:0] S_QRD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  function automatic logic [QW-1:0] qnext(input logic [QW-1:0] i);
    logic [QW:0] inc;
    inc = {1'b0, i} + (QW+1)'(1);
    return (inc >= (QW+1)'(QUEUE_DEPTH)) ? '0 : inc[QW-1:0];
  endfunction

  logic [2:0]         state;
  logic [SW-1:0]      top;
  logic [STATE_W-1:0] top_state;
  logic [QW-1:0]      top_head;
  logic [QW-1:0]      top_tail;
  logic [STATE_W-1:0] below_state;
  logic [STATE_W-1:0] low_state;
  logic [QW-1:0]      low_head;
  logic [QW-1:0]      low_tail;
  logic               rd_pend;
  logic               is_pop;
  logic               is_qry;
  logic [STATE_W-1:0] qry_val;
  logic [STATE_W-1:0] prev;
  logic [EVENT_W-1:0] ev_out;
  logic               ev_valid;
  logic               changed;
  logic [STAT_W-1:0]  status;

  logic               ev_we;
  logic [EAW-1:0]     ev_waddr;
  logic [EVENT_W-1:0] ev_wdata;
  logic [EAW-1:0]     ev_raddr;
  logic [EVENT_W-1:0] ev_rdata;
  logic               lv_we;
  logic [SW-1:0]      lv_waddr;
  logic [LW-1:0]      lv_wdata;
  logic [SW-1:0]      lv_raddr;
  logic [LW-1:0]      lv_rdata;

  logic               in_fire;
  logic               top_empty;
  logic               top_full;
  logic               low_full;
  logic [SW-1:0]      top_m1;
  logic [DW-1:0]      top_ext;
  logic [DW-1:0]      depth_ext;
  logic               depth_bad;
  logic [SW-1:0]      qry_addr;
  logic               push_ok;
  logic [STATE_W-1:0] lv_rd_state;
  logic [QW-1:0]      lv_rd_head;
  logic [QW-1:0]      lv_rd_tail;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign top_empty = (top_head == top_tail);
  assign top_full  = (qnext(top_tail) == top_head);
  assign low_full  = (qnext(low_tail) == low_head);
  assign top_m1    = top - SW'(1);
  assign top_ext   = DW'(top);
  assign depth_ext = DW'(in_cmd.query_depth);
  assign depth_bad = (depth_ext > top_ext);
  assign qry_addr  = SW'(top_ext - depth_ext);
  assign push_ok   = (in_cmd.target_state != top_state) && (top != TOP_MAX);
  assign {lv_rd_state, lv_rd_head, lv_rd_tail} = lv_rdata;

  // memory port steering
  always_comb begin
    ev_we    = 1'b0;
    ev_waddr = {top, top_tail};
    ev_wdata = in_cmd.event_code;
    ev_raddr = {top, top_head};
    lv_we    = 1'b0;
    lv_waddr = top;
    lv_wdata = {top_state, top_head, top_tail};
    lv_raddr = top_m1;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd.opcode)
            OP_POST:  ev_we = !top_full;
            OP_PUSH:  lv_we = push_ok;
            OP_QUERY: lv_raddr = qry_addr;
            default: ;
          endcase
        end
      end
      S_MIG: begin
        if (rd_pend && !low_full) begin
          ev_we    = 1'b1;
          ev_waddr = {top_m1, low_tail};
          ev_wdata = ev_rdata;
        end
      end
      default: ;
    endcase
  end

  ssq_ram #(.WIDTH(EVENT_W), .ADDR_W(EAW)) u_ev_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  ssq_ram #(.WIDTH(LW), .ADDR_W(SW)) u_lv_ram (
    .clk   (clk),
    .we    (lv_we),
    .waddr (lv_waddr),
    .wdata (lv_wdata),
    .raddr (lv_raddr),
    .rdata (lv_rdata)
  );

  // sequencer and top-level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      top_state <= '0;
      top_head  <= '0;
      top_tail  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_OUT;
            unique case (in_cmd.opcode)
              OP_POST: begin
                if (!top_full) top_tail <= qnext(top_tail);
              end
              OP_GET: begin
                if (!top_empty) begin
                  top_head <= qnext(top_head);
                  state    <= S_GETRD;
                end
              end
              OP_SET: begin
                if (in_cmd.target_state != top_state || in_cmd.force_change) begin
                  top_head  <= top_tail;
                  top_state <= in_cmd.target_state;
                end
              end
              OP_PUSH: begin
                if (push_ok) begin
                  top       <= top + SW'(1);
                  top_state <= in_cmd.target_state;
                  top_head  <= '0;
                  top_tail  <= '0;
                end
              end
              OP_POP, OP_DISCARD: begin
                if (top != '0) state <= S_LVRD;
              end
              OP_QUERY: begin
                if (in_cmd.query_depth != '0 && !depth_bad) state <= S_QRD;
              end
              default: ;
            endcase
          end
        end
        S_GETRD: state <= S_OUT;
        S_QRD:   state <= S_OUT;
        S_LVRD: begin
          if (is_pop) begin
            state <= S_MIG;
          end else begin
            top       <= top_m1;
            top_state <= lv_rd_state;
            top_head  <= lv_rd_head;
            top_tail  <= lv_rd_tail;
            state     <= S_FIN;
          end
        end
        S_MIG: begin
          if (!top_empty) begin
            top_head <= qnext(top_head);
          end else if (!rd_pend) begin
            // queue drained: lower level becomes the top
            top       <= top_m1;
            top_state <= low_state;
            top_head  <= low_head;
            top_tail  <= low_tail;
            state     <= S_FIN;
          end
        end
        S_FIN:   state <= (top != '0) ? S_BELOW : S_OUT;
        S_BELOW: state <= S_OUT;
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // per-item working and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          prev     <= top_state;
          ev_out   <= '0;
          ev_valid <= 1'b0;
          changed  <= 1'b0;
          status   <= STAT_OK;
          is_qry   <= 1'b0;
          qry_val  <= '0;
          rd_pend  <= 1'b0;
          is_pop   <= (in_cmd.opcode == OP_POP);
          unique case (in_cmd.opcode)
            OP_POST: begin
              if (top_full) status <= STAT_QFULL;
            end
            OP_SET: begin
              if (in_cmd.target_state != top_state || in_cmd.force_change) changed <= 1'b1;
            end
            OP_PUSH: begin
              if (in_cmd.target_state != top_state) begin
                if (top == TOP_MAX) begin
                  status <= STAT_OVERFLOW;
                end else begin
                  changed     <= 1'b1;
                  below_state <= top_state;
                end
              end
            end
            OP_QUERY: begin
              is_qry <= 1'b1;
              if (in_cmd.query_depth == '0) begin
                qry_val <= top_state;
              end else if (depth_bad) begin
                status <= STAT_BADDEPTH;
              end
            end
            default: ;
          endcase
        end
      end
      S_GETRD: begin
        ev_out   <= ev_rdata;
        ev_valid <= 1'b1;
      end
      S_QRD: qry_val <= lv_rd_state;
      S_LVRD: begin
        low_state <= lv_rd_state;
        low_head  <= lv_rd_head;
        low_tail  <= lv_rd_tail;
      end
      S_MIG: begin
        if (rd_pend) begin
          if (low_full) status <= STAT_MIGDROP;
          else          low_tail <= qnext(low_tail);
        end
        rd_pend <= !top_empty;
        if (top_empty && !rd_pend) changed <= 1'b1;
      end
      S_BELOW: below_state <= lv_rd_state;
      default: ;
    endcase
  end

  assign res_load = (state == S_OUT) && out_free;

  always_comb begin
    res.event_out      = ev_out;
    res.event_valid    = ev_valid;
    res.state_out      = is_qry ? qry_val : top_state;
    res.previous_state = prev;
    res.state_changed  = changed;
    res.stack_level    = LEVEL_W'(top);
    res.pushed_state   = (top != '0) ? below_state : '0;
    res.pushed_valid   = (top != '0);
    res.status         = status;
  end

endmodule

`default_nettype wire
